/* rtl/core/drc_pkg.sv */
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants for the dirty range coalescer and its cells.
// ----------------------------------------------------------------------------
package drc_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int ADDR_BITS_DEF = 32;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ABSORB,
      CELL_INSERT,
      CELL_WIDEN,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

   // status one cell shows its neighbours
   typedef struct packed {
      logic valid;
      logic lt;      // start below the pending low bound
      logic ov_any;  // this cell or one below it touches the pending range
      logic is_pad;  // stands beyond either end of the chain
   } link_type;

   localparam link_type LINK_PAD_LOW  = '{valid: 1'b1, lt: 1'b1, ov_any: 1'b0, is_pad: 1'b1};
   localparam link_type LINK_PAD_HIGH = '{valid: 1'b0, lt: 1'b0, ov_any: 1'b0, is_pad: 1'b1};

endpackage

/* rtl/core/drc_cell.sv */
// ----------------------------------------------------------------------------
// drc_cell
// One interval slot of the sorted chain: compares itself with the pending
// range and takes data from a neighbour when the chain moves.
// ----------------------------------------------------------------------------
module drc_cell #(
   parameter int ADDR_BITS = drc_pkg::ADDR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  drc_pkg::cell_ctrl_type  ctrl,
   input  logic [ADDR_BITS-1:0]    lo,
   input  logic [ADDR_BITS:0]      hi,
   input  drc_pkg::link_type       prev_link,
   input  logic [ADDR_BITS-1:0]    prev_start,
   input  logic [ADDR_BITS:0]      prev_end,
   input  drc_pkg::link_type       next_link,
   input  logic [ADDR_BITS-1:0]    next_start,
   input  logic [ADDR_BITS:0]      next_end,
   output drc_pkg::link_type       link,
   output logic [ADDR_BITS-1:0]    cell_start,
   output logic [ADDR_BITS:0]      cell_end
);

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS:0]   end_ff, end_in;
   logic                 valid_ff, valid_in;
   logic                 ov;
   logic                 lt;

   assign ov = valid_ff && ({1'b0, lo} <= end_ff) && ({1'b0, start_ff} <= hi);
   assign lt = valid_ff && (start_ff < lo);

   always_comb begin
      link.valid  = valid_ff;
      link.lt     = lt;
      link.ov_any = prev_link.ov_any | ov;
      link.is_pad = 1'b0;
   end

   assign cell_start = start_ff;
   assign cell_end   = end_ff;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         drc_pkg::CELL_ABSORB: begin
            if (prev_link.ov_any || ov) begin
               start_in = next_start;
               end_in   = next_end;
               valid_in = next_link.valid;
            end
         end
         drc_pkg::CELL_INSERT: begin
            if (!prev_link.lt) begin
               start_in = prev_start;
               end_in   = prev_end;
               valid_in = prev_link.valid;
            end else if (!lt) begin
               start_in = lo;
               end_in   = hi;
               valid_in = 1'b1;
            end
         end
         drc_pkg::CELL_WIDEN: begin
            if (lt && !next_link.lt) begin
               if (hi > end_ff) begin
                  end_in = hi;
               end
            end else if (prev_link.is_pad && !lt) begin
               start_in = lo;
            end
         end
         drc_pkg::CELL_SHIFT: begin
            start_in = next_start;
            end_in   = next_end;
            valid_in = next_link.valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

endmodule

/* rtl/core/dirty_range_coalescer.sv */
// ----------------------------------------------------------------------------
// dirty_range_coalescer
// Keeps a sorted set of disjoint dirty byte intervals in a chain of cells,
// merges recorded ranges into it and streams the set out on a flush.
// ----------------------------------------------------------------------------
//  channel | ports   | word
//  --------+---------+------------------------------------------------
//  input   | req_*   | req_type, req_range_start, req_range_end
//  result  | rsp_*   | rsp_flush_start, rsp_flush_end, rsp_last_range,
//          |         | rsp_overflowed
//
//  Record: held intervals it merges with leave the chain one per cycle.
//  Flush: one chain shift per word emitted.
//  Synchronous reset empties the set and clears the overflow flag.
//  rsp_ready low holds the chain; req_ready is low until the word is done.
// ----------------------------------------------------------------------------
module dirty_range_coalescer #(
   parameter int DEPTH     = drc_pkg::DEPTH_DEF,
   parameter int ADDR_BITS = drc_pkg::ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [ADDR_BITS-1:0] req_range_start,
   input  logic [ADDR_BITS:0]   req_range_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_BITS-1:0] rsp_flush_start,
   output logic [ADDR_BITS:0]   rsp_flush_end,
   output logic                 rsp_last_range,
   output logic                 rsp_overflowed
);

   localparam logic [ADDR_BITS:0] END_MAX = {1'b1, {ADDR_BITS{1'b0}}};

   drc_pkg::state_type     state_ff, state_in;
   logic                   ovf_ff, ovf_in;
   logic [ADDR_BITS-1:0]   lo_ff, lo_in;
   logic [ADDR_BITS:0]     hi_ff, hi_in;
   drc_pkg::cell_ctrl_type ctrl;

   drc_pkg::link_type      link      [DEPTH];
   drc_pkg::link_type      prev_link [DEPTH];
   drc_pkg::link_type      next_link [DEPTH];
   logic [ADDR_BITS-1:0]   cell_start [DEPTH];
   logic [ADDR_BITS:0]     cell_end   [DEPTH];
   logic [ADDR_BITS-1:0]   prev_start [DEPTH];
   logic [ADDR_BITS:0]     prev_end   [DEPTH];
   logic [ADDR_BITS-1:0]   next_start [DEPTH];
   logic [ADDR_BITS:0]     next_end   [DEPTH];

   logic [ADDR_BITS-1:0]   sel_start;
   logic [ADDR_BITS:0]     sel_end;
   logic [ADDR_BITS:0]     end_sat;
   logic [ADDR_BITS:0]     end_fix;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      if (j == 0) begin : g_lo
         assign prev_link[j]  = drc_pkg::LINK_PAD_LOW;
         assign prev_start[j] = '0;
         assign prev_end[j]   = '0;
      end else begin : g_lo
         assign prev_link[j]  = link[j-1];
         assign prev_start[j] = cell_start[j-1];
         assign prev_end[j]   = cell_end[j-1];
      end
      if (j == DEPTH - 1) begin : g_hi
         assign next_link[j]  = drc_pkg::LINK_PAD_HIGH;
         assign next_start[j] = '0;
         assign next_end[j]   = '0;
      end else begin : g_hi
         assign next_link[j]  = link[j+1];
         assign next_start[j] = cell_start[j+1];
         assign next_end[j]   = cell_end[j+1];
      end

      drc_cell #(
         .ADDR_BITS (ADDR_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .lo         (lo_ff),
         .hi         (hi_ff),
         .prev_link  (prev_link[j]),
         .prev_start (prev_start[j]),
         .prev_end   (prev_end[j]),
         .next_link  (next_link[j]),
         .next_start (next_start[j]),
         .next_end   (next_end[j]),
         .link       (link[j]),
         .cell_start (cell_start[j]),
         .cell_end   (cell_end[j])
      );
   end

   // lowest touching cell, picked where the prefix flag rises
   always_comb begin
      sel_start = '0;
      sel_end   = '0;
      for (int j = 0; j < DEPTH; j++) begin
         if (link[j].ov_any && !prev_link[j].ov_any) begin
            sel_start = sel_start | cell_start[j];
            sel_end   = sel_end | cell_end[j];
         end
      end
   end

   always_comb begin
      end_sat = req_range_end;
      if (req_range_end[ADDR_BITS] && (|req_range_end[ADDR_BITS-1:0])) begin
         end_sat = END_MAX;
      end
      end_fix = end_sat;
      if (end_sat < {1'b0, req_range_start}) begin
         end_fix = {1'b0, req_range_start};
      end
   end

   assign req_ready       = (state_ff == drc_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == drc_pkg::ST_FLUSH) && link[0].valid;
   assign rsp_flush_start = cell_start[0];
   assign rsp_flush_end   = cell_end[0];
   assign rsp_last_range  = !next_link[0].valid;
   assign rsp_overflowed  = ovf_ff;

   always_comb begin
      state_in = state_ff;
      ovf_in   = ovf_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      ctrl.op  = drc_pkg::CELL_HOLD;
      case (state_ff)
         drc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == drc_pkg::REQ_FLUSH) begin
                  state_in = drc_pkg::ST_FLUSH;
               end else begin
                  lo_in    = req_range_start;
                  hi_in    = end_fix;
                  state_in = drc_pkg::ST_MERGE;
               end
            end
         end
         drc_pkg::ST_MERGE: begin
            if (link[DEPTH-1].ov_any) begin
               ctrl.op = drc_pkg::CELL_ABSORB;
               if (sel_start < lo_ff) begin
                  lo_in = sel_start;
               end
               if (sel_end > hi_ff) begin
                  hi_in = sel_end;
               end
            end else if (link[DEPTH-1].valid) begin
               ctrl.op  = drc_pkg::CELL_WIDEN;
               ovf_in   = 1'b1;
               state_in = drc_pkg::ST_IDLE;
            end else begin
               ctrl.op  = drc_pkg::CELL_INSERT;
               state_in = drc_pkg::ST_IDLE;
            end
         end
         drc_pkg::ST_FLUSH: begin
            if (!link[0].valid) begin
               ovf_in   = 1'b0;
               state_in = drc_pkg::ST_IDLE;
            end else if (rsp_ready) begin
               ctrl.op = drc_pkg::CELL_SHIFT;
            end
         end
         default: begin
            state_in = drc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drc_pkg::ST_IDLE;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

endmodule

/* rtl/core/drc_checker.sv */
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks on the dirty range coalescer, bound to the top level.
// ----------------------------------------------------------------------------
module drc_checker #(
   parameter int ADDR_BITS = drc_pkg::ADDR_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_type,
   input logic [ADDR_BITS-1:0] req_range_start,
   input logic [ADDR_BITS:0]   req_range_end,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ADDR_BITS-1:0] rsp_flush_start,
   input logic [ADDR_BITS:0]   rsp_flush_end,
   input logic                 rsp_last_range,
   input logic                 rsp_overflowed
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type)
         && $stable(req_range_start) && $stable(req_range_end))
      else $error("request word changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flush_start)
         && $stable(rsp_flush_end) && $stable(rsp_last_range))
      else $error("result word changed while stalled");

   a_no_req_in_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during a flush");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_range |=>
         rsp_valid && ({1'b0, rsp_flush_start} > $past(rsp_flush_end))
         && (rsp_overflowed == $past(rsp_overflowed)))
      else $error("flush words not disjoint and ascending");

   a_well_formed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_flush_end >= {1'b0, rsp_flush_start})
      else $error("interval end below start");

endmodule

bind dirty_range_coalescer drc_checker #(.ADDR_BITS(ADDR_BITS)) u_drc_checker (.*);

/* sim/coalesce_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalesce_checker
// Watches both channels of the dirty range coalescer, keeps its own sorted
// set of merged intervals, and checks every flushed word against it.
// ----------------------------------------------------------------------------
module coalesce_checker #(
   parameter int DEPTH = drc_pkg::DEPTH_DEF,
   parameter int AW    = drc_pkg::ADDR_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  logic          req_type,
   input  logic [AW-1:0] req_range_start,
   input  logic [AW:0]   req_range_end,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic [AW-1:0] rsp_flush_start,
   input  logic [AW:0]   rsp_flush_end,
   input  logic          rsp_last_range,
   input  logic          rsp_overflowed,
   output int            mismatches,
   output int            outstanding
);

   localparam logic [AW:0] END_CAP = {1'b1, {AW{1'b0}}};

   typedef struct packed {
      logic [AW-1:0] lo;
      logic [AW:0]   hi;
      logic          last;
      logic          ovf;
   } span_word_type;

   logic [AW-1:0] held_lo [DEPTH];
   logic [AW:0]   held_hi [DEPTH];
   logic          held_used [DEPTH];
   logic          widened;
   span_word_type spans_due [$];
   int            err_count;

   // merge one recorded range into the held set
   function automatic void fold_range(input logic [AW-1:0] s, input logic [AW:0] e_raw);
      logic [AW-1:0] ks [DEPTH+1];
      logic [AW:0]   ke [DEPTH+1];
      logic [AW:0]   e;
      logic [AW-1:0] lo;
      logic [AW:0]   hi;
      int            kept;
      int            pos;
      int            k;
      int            i;
      e = e_raw;
      if (e > END_CAP) e = END_CAP;
      if (e < {1'b0, s}) e = {1'b0, s};
      lo   = s;
      hi   = e;
      kept = 0;
      for (i = 0; i < DEPTH; i++) begin
         if (held_used[i]) begin
            if ({1'b0, s} <= held_hi[i] && {1'b0, held_lo[i]} <= e) begin
               if (held_lo[i] < lo) lo = held_lo[i];
               if (held_hi[i] > hi) hi = held_hi[i];
            end else begin
               ks[kept] = held_lo[i];
               ke[kept] = held_hi[i];
               kept++;
            end
         end
      end
      if (kept < DEPTH) begin
         pos = kept;
         while (pos > 0 && ks[pos-1] > lo) begin
            ks[pos] = ks[pos-1];
            ke[pos] = ke[pos-1];
            pos--;
         end
         ks[pos] = lo;
         ke[pos] = hi;
         kept++;
      end else begin
         // full and untouched: widen the nearest lower interval, or else extend the lowest one down
         k = -1;
         for (i = 0; i < kept; i++) begin
            if (ks[i] < s) k = i;
         end
         if (k >= 0) begin
            if (e > ke[k]) ke[k] = e;
         end else begin
            ks[0] = s;
         end
         widened = 1'b1;
      end
      for (i = 0; i < DEPTH; i++) begin
         held_used[i] = (i < kept);
         if (i < kept) begin
            held_lo[i] = ks[i];
            held_hi[i] = ke[i];
         end
      end
   endfunction

   function automatic void drain_spans();
      span_word_type w;
      int            n;
      int            i;
      n = 0;
      for (i = 0; i < DEPTH; i++) begin
         if (held_used[i]) n++;
      end
      for (i = 0; i < n; i++) begin
         w.lo   = held_lo[i];
         w.hi   = held_hi[i];
         w.last = (i == n - 1);
         w.ovf  = widened;
         spans_due.push_back(w);
      end
      for (i = 0; i < DEPTH; i++) held_used[i] = 1'b0;
      widened = 1'b0;
   endfunction

   always @(posedge clock) begin
      span_word_type want;
      int            i;
      if (reset) begin
         for (i = 0; i < DEPTH; i++) held_used[i] = 1'b0;
         widened = 1'b0;
         spans_due.delete();
         err_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (spans_due.size() == 0) begin
               $error("flush word with none due: start %h end %h", rsp_flush_start,
                      rsp_flush_end);
               err_count++;
            end else begin
               want = spans_due.pop_front();
               if (rsp_flush_start !== want.lo) begin
                  $error("flush_start: expected %h, got %h", want.lo, rsp_flush_start);
                  err_count++;
               end
               if (rsp_flush_end !== want.hi) begin
                  $error("flush_end: expected %h, got %h", want.hi, rsp_flush_end);
                  err_count++;
               end
               if (rsp_last_range !== want.last) begin
                  $error("last_range: expected %b, got %b", want.last, rsp_last_range);
                  err_count++;
               end
               if (rsp_overflowed !== want.ovf) begin
                  $error("overflowed: expected %b, got %b", want.ovf, rsp_overflowed);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == drc_pkg::REQ_FLUSH) drain_spans();
            else fold_range(req_range_start, req_range_end);
         end
      end
      mismatches  <= err_count;
      outstanding <= spans_due.size();
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives record and flush words into the dirty range coalescer with random
// gaps and result stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH       = drc_pkg::DEPTH_DEF;
   localparam int AW          = drc_pkg::ADDR_BITS_DEF;
   localparam int WORD_TARGET = 180;
   localparam int CYCLE_LIMIT = 500000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          req_type;
   logic [AW-1:0] req_range_start;
   logic [AW:0]   req_range_end;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [AW-1:0] rsp_flush_start;
   logic [AW:0]   rsp_flush_end;
   logic          rsp_last_range;
   logic          rsp_overflowed;
   int            mismatches;
   int            outstanding;
   int            cycle_count = 0;
   int            words_sent  = 0;
   logic          quiet       = 1'b0;

   dirty_range_coalescer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_flush_start (rsp_flush_start),
      .rsp_flush_end   (rsp_flush_end),
      .rsp_last_range  (rsp_last_range),
      .rsp_overflowed  (rsp_overflowed)
   );

   coalesce_checker coalesce_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_flush_start (rsp_flush_start),
      .rsp_flush_end   (rsp_flush_end),
      .rsp_last_range  (rsp_last_range),
      .rsp_overflowed  (rsp_overflowed),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input logic no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: ready runs broken by stalls
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input logic t, input logic [AW-1:0] s, input logic [AW:0] e);
      int gap;
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= t;
      req_range_start <= s;
      req_range_end   <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic record_range(input logic [AW-1:0] s, input logic [AW:0] e);
      send_word(drc_pkg::REQ_RECORD, s, e);
   endtask

   task automatic flush_set();
      send_word(drc_pkg::REQ_FLUSH, $urandom(), {1'($urandom_range(0, 1)), 32'($urandom())});
   endtask

   initial begin
      int            i;
      int            n;
      int            kind;
      int            spread;
      logic          long_batch;
      logic [AW-1:0] base;
      logic [AW-1:0] s;
      logic [AW:0]   e;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = drc_pkg::REQ_RECORD;
      req_range_start = '0;
      req_range_end   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty set, empty range, inverted range, saturation, touching merges
      flush_set();
      record_range(32'd0, 33'd0);
      record_range(32'd10, 33'd5);
      record_range(32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
      record_range(32'd5, 33'd10);
      record_range(32'd0, 33'd5);
      flush_set();

      // fill the set, then overflow with and without a lower neighbour
      for (i = 0; i < DEPTH; i++) record_range(32'(1000 + 100 * i), 33'(1010 + 100 * i));
      record_range(32'd10, 33'd20);
      record_range(32'd5000, 33'd5020);
      flush_set();

      // random batches of records closed by a flush
      while (words_sent < WORD_TARGET) begin
         quiet      = ($urandom_range(0, 4) == 0);
         long_batch = ($urandom_range(0, 4) == 0);
         n          = long_batch ? $urandom_range(14, 24) : $urandom_range(0, 8);
         spread     = long_batch ? 4095 : 255;
         case ($urandom_range(0, 2))
            0: base = $urandom_range(0, 1023);
            1: base = $urandom();
            default: base = 32'hFFFF_FFFF - $urandom_range(0, 8191);
         endcase
         for (i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
               flush_set();
            end else if (kind < 20) begin
               record_range($urandom(), {1'($urandom_range(0, 1)), 32'($urandom())});
            end else begin
               s = base + 32'($urandom_range(0, spread));
               e = {1'b0, s} + 33'($urandom_range(0, 24));
               record_range(s, e);
            end
         end
         flush_set();
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
